// ===== rtl/kway_sorted_stream_merge_assert.svh =====
// assertion macros shared by the merge checker
`ifndef KWAY_SORTED_STREAM_MERGE_ASSERT_SVH
`define KWAY_SORTED_STREAM_MERGE_ASSERT_SVH

// property that must hold in the same cycle, outside reset
`define KWSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property whose consequent is checked in the next cycle, outside reset
`define KWSM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

// ===== rtl/kwsm_pkg.sv =====
// types and constants of the k-way sorted stream merge
`default_nettype none

package kwsm_pkg;

  localparam int WORD_W = 64;
  localparam int SRC_W  = 4;
  localparam int MODE_W = 2;
  localparam int CFG_W  = 5;
  localparam int CNT_W  = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_WORD    = 2'd0,
    MODE_EXHAUST = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_WORD   = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_EXHAUSTED = 2'd0,
    ST_AWAITING  = 2'd1,
    ST_HOLDING   = 2'd2
  } st_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SRC_W-1:0]  idx;
    logic [WORD_W-1:0] word;
  } item_t;

  typedef struct packed {
    logic              vld;
    kind_t             kind;
    logic [WORD_W-1:0] value;
    logic [SRC_W-1:0]  src;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/kwsm_min_tree.sv =====
// compare tree picking the smallest valid head, ties to the lower stream
`default_nettype none

module kwsm_min_tree #(
  parameter int N = 16
) (
  input  logic [N-1:0]                   leaf_vld,
  input  logic [kwsm_pkg::WORD_W-1:0]    leaf_val [N],
  output logic                           min_any,
  output logic [$clog2(N)-1:0]           min_idx,
  output logic [kwsm_pkg::WORD_W-1:0]    min_val
);
  import kwsm_pkg::*;

  localparam int IDX_W  = $clog2(N);
  localparam int LEVELS = $clog2(N);
  localparam int P      = 1 << LEVELS;

  logic              nd_vld [2*P-1];
  logic [WORD_W-1:0] nd_val [2*P-1];
  logic [IDX_W-1:0]  nd_idx [2*P-1];

  // leaves, padded to a power of two with empty slots
  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_real
      assign nd_vld[P-1+i] = leaf_vld[i];
      assign nd_val[P-1+i] = leaf_val[i];
      assign nd_idx[P-1+i] = IDX_W'(i);
    end else begin : g_pad
      assign nd_vld[P-1+i] = 1'b0;
      assign nd_val[P-1+i] = '0;
      assign nd_idx[P-1+i] = '0;
    end
  end

  // inner nodes: the right child wins only when strictly smaller
  for (genvar k = 0; k < P-1; k++) begin : g_node
    logic pick_hi;
    assign pick_hi = nd_vld[2*k+2] &&
                     (!nd_vld[2*k+1] || (nd_val[2*k+2] < nd_val[2*k+1]));
    assign nd_vld[k] = nd_vld[2*k+1] || nd_vld[2*k+2];
    assign nd_val[k] = pick_hi ? nd_val[2*k+2] : nd_val[2*k+1];
    assign nd_idx[k] = pick_hi ? nd_idx[2*k+2] : nd_idx[2*k+1];
  end

  assign min_any = nd_vld[0];
  assign min_idx = nd_idx[0];
  assign min_val = nd_val[0];

endmodule

`default_nettype wire

// ===== rtl/kwsm_core.sv =====
// stream heads, stream status and the merge decision for one transaction
`default_nettype none

module kwsm_core #(
  parameter int MAX_STREAMS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  kwsm_pkg::item_t             item_i,
  input  logic [kwsm_pkg::CFG_W-1:0]  cfg_streams,
  output kwsm_pkg::res_t              res_o
);
  import kwsm_pkg::*;

  localparam int IDX_W = $clog2(MAX_STREAMS);

  st_t               st_r   [MAX_STREAMS];
  st_t               st_nxt [MAX_STREAMS];
  st_t               st_upd [MAX_STREAMS];
  logic [WORD_W-1:0] head_r [MAX_STREAMS];
  logic [WORD_W-1:0] leaf_val [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] leaf_vld;
  logic [MAX_STREAMS-1:0] wait_vec;
  logic              fin_r;
  logic              fin_nxt;
  logic              is_word;
  logic              is_exh;
  logic              is_rst;
  logic              idx_ok;
  logic              awaiting;
  logic              take;
  logic              any_wait;
  logic              hd_we;
  logic              min_any;
  logic [IDX_W-1:0]  min_idx;
  logic [WORD_W-1:0] min_val;
  logic [CNT_W-1:0]  eff_cfg;
  logic [CNT_W-1:0]  eff_rst;

  // stream count clamped to 1..MAX_STREAMS
  function automatic logic [CNT_W-1:0] eff_count(logic [CFG_W-1:0] n);
    logic [CNT_W-1:0] w;
    w = CNT_W'(n);
    if (w == '0) return CNT_W'(1);
    if (int'(w) > MAX_STREAMS) return CNT_W'(MAX_STREAMS);
    return w;
  endfunction

  // status of a stream right after a restart
  function automatic st_t init_st(logic [CNT_W-1:0] eff, int i);
    return (i < int'(eff)) ? ST_AWAITING : ST_EXHAUSTED;
  endfunction

  assign eff_cfg = eff_count(cfg_streams);
  assign eff_rst = eff_count(CFG_RESET);

  // decode of the transaction
  assign is_word  = (item_i.mode == MODE_WORD);
  assign is_exh   = (item_i.mode == MODE_EXHAUST);
  assign is_rst   = (item_i.mode == MODE_RESTART);
  assign idx_ok   = (int'(item_i.idx) < MAX_STREAMS);
  assign awaiting = idx_ok && (st_r[IDX_W'(item_i.idx)] == ST_AWAITING);
  assign take     = (is_word || is_exh) && awaiting;
  assign hd_we    = fire && take && is_word;

  // status after the refill or exhaustion, and the leaves it exposes
  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      st_upd[i]   = st_r[i];
      leaf_val[i] = head_r[i];
      if (take && (int'(item_i.idx) == i)) begin
        st_upd[i] = is_word ? ST_HOLDING : ST_EXHAUSTED;
        if (is_word) begin
          leaf_val[i] = item_i.word;
        end
      end
      leaf_vld[i] = (st_upd[i] == ST_HOLDING);
      wait_vec[i] = (st_upd[i] == ST_AWAITING);
    end
  end

  assign any_wait = |wait_vec;

  kwsm_min_tree #(
    .N (MAX_STREAMS)
  ) u_tree (
    .leaf_vld (leaf_vld),
    .leaf_val (leaf_val),
    .min_any  (min_any),
    .min_idx  (min_idx),
    .min_val  (min_val)
  );

  // merge decision and next status
  always_comb begin
    st_nxt  = st_r;
    fin_nxt = fin_r;
    res_o   = '0;
    if (fire) begin
      if (is_rst) begin
        for (int i = 0; i < MAX_STREAMS; i++) begin
          st_nxt[i] = init_st(eff_cfg, i);
        end
        fin_nxt = 1'b0;
      end else if (!take) begin
        res_o.vld  = 1'b1;
        res_o.kind = KIND_REJECT;
        res_o.src  = item_i.idx;
      end else begin
        st_nxt = st_upd;
        if (!any_wait) begin
          if (min_any) begin
            st_nxt[min_idx] = ST_AWAITING;
            res_o.vld   = 1'b1;
            res_o.kind  = KIND_WORD;
            res_o.value = min_val;
            res_o.src   = SRC_W'(min_idx);
          end else if (!fin_r) begin
            fin_nxt    = 1'b1;
            res_o.vld  = 1'b1;
            res_o.kind = KIND_FINISH;
          end
        end
      end
    end
  end

  // status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_STREAMS; i++) begin
        st_r[i] <= init_st(eff_rst, i);
      end
      fin_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      fin_r <= fin_nxt;
    end
  end

  // head words, read only while their stream holds a word
  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_r[IDX_W'(item_i.idx)] <= item_i.word;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/kway_sorted_stream_merge.sv =====
// an accepted transaction is held in the input register, and its result, if any, in the result register
// throughput: one transaction per cycle while the result side keeps draining
// the cycle is set by the compare tree over MAX_STREAMS head words plus one refill
// reset: synchronous, active low; stream count returns to 16, first streams await words
// head words are not cleared; no clearing pass follows reset
`default_nettype none

module kway_sorted_stream_merge #(
  parameter int MAX_STREAMS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_stream_index,
  input  logic [63:0] in_word_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [63:0] out_merged_value,
  output logic [3:0]  out_source_stream
);
  import kwsm_pkg::*;

  logic [CFG_W-1:0] cfg_streams_r;
  logic             inr_vld_r;
  item_t            inr_item_r;
  logic             out_vld_r;
  res_t             out_res_r;
  res_t             res;
  logic             out_free;
  logic             fire;
  logic             in_acc;

  // handshake: the input register moves on when the result slot is free
  assign out_free = !out_vld_r || !out_stall;
  assign fire     = inr_vld_r && out_free;
  assign in_stall = inr_vld_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // stream count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_streams_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_streams_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inr_vld_r <= 1'b0;
    end else if (in_acc) begin
      inr_vld_r <= 1'b1;
    end else if (fire) begin
      inr_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      inr_item_r.mode <= in_mode;
      inr_item_r.idx  <= in_stream_index;
      inr_item_r.word <= in_word_value;
    end
  end

  kwsm_core #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item_i      (inr_item_r),
    .cfg_streams (cfg_streams_r),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && res.vld) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_result_kind   = out_res_r.kind;
  assign out_merged_value  = out_res_r.value;
  assign out_source_stream = out_res_r.src;

endmodule

`default_nettype wire

// ===== rtl/kwsm_checker.sv =====
// port-level checks of the merge block and their bind
`include "kway_sorted_stream_merge_assert.svh"
`default_nettype none

module kwsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic [4:0]  cfg_wr_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_mode,
  input logic [3:0]  in_stream_index,
  input logic [63:0] in_word_value,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_result_kind,
  input logic [63:0] out_merged_value,
  input logic [3:0]  out_source_stream
);
  import kwsm_pkg::*;

  // a held result stays offered
  `KWSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // a held result keeps its value
  `KWSM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_merged_value) && $stable(out_source_stream), "stalled result changed")

  // input back-pressure only comes from a stalled full result slot
  `KWSM_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without a full result")

  // reject results carry no word
  `KWSM_ASSERT(a_reject_zero, (out_valid && (out_result_kind == KIND_REJECT)) |-> (out_merged_value == '0), "reject with a word")

  // finish results carry neither word nor stream
  `KWSM_ASSERT(a_finish_zero, (out_valid && (out_result_kind == KIND_FINISH)) |-> ((out_merged_value == '0) && (out_source_stream == '0)), "finish with payload")

endmodule

bind kway_sorted_stream_merge kwsm_checker u_kwsm_checker (.*);

`default_nettype wire
